>>> hw/rtl/elevator_target_selector_top_macros.svh
`ifndef ELEVATOR_TARGET_SELECTOR_TOP_MACROS_SVH
`define ELEVATOR_TARGET_SELECTOR_TOP_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define ETS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define ETS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ets_pkg.sv
package ets_pkg;

  localparam int FLOORS  = 16;
  localparam int FLOOR_W = 6;
  localparam int OP_W    = 2;
  localparam int PF_W    = (FLOORS > 1) ? $clog2(FLOORS) : 1;

  localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
  localparam logic [OP_W-1:0] OP_ARRIVE  = 2'd1;
  localparam logic [OP_W-1:0] OP_PASS    = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [FLOOR_W-1:0] floor;
    logic               moving_up;
  } item_t;

  typedef struct packed {
    logic               target_valid;
    logic [FLOOR_W-1:0] target_floor;
    logic               car_busy;
  } result_t;

  typedef struct packed {
    logic            found;
    logic [PF_W-1:0] idx;
  } seek_t;

  function automatic logic [PF_W-1:0] lowest_set(input logic [FLOORS-1:0] v);
    logic [PF_W-1:0] idx;
    idx = '0;
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = PF_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [PF_W-1:0] highest_set(input logic [FLOORS-1:0] v);
    logic [PF_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < FLOORS; i++) begin
      if (v[i]) begin
        idx = PF_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> hw/rtl/ets_seek.sv
module ets_seek (
  input  logic [ets_pkg::FLOORS-1:0] req,
  input  logic [ets_pkg::PF_W-1:0]   present_floor,
  input  logic                       heading_up,
  output ets_pkg::seek_t             seek
);

  logic [ets_pkg::FLOORS-1:0] up_mask;
  logic [ets_pkg::FLOORS-1:0] down_mask;

  always_comb begin
    for (int i = 0; i < ets_pkg::FLOORS; i++) begin
      up_mask[i]   = req[i] && (ets_pkg::PF_W'(i) >= present_floor);
      down_mask[i] = req[i] && (ets_pkg::PF_W'(i) <= present_floor);
    end
  end

  always_comb begin
    seek.found = |req;
    if (heading_up) begin
      if (|up_mask) begin
        seek.idx = ets_pkg::lowest_set(up_mask);
      end else begin
        seek.idx = ets_pkg::highest_set(down_mask);
      end
    end else begin
      if (|down_mask) begin
        seek.idx = ets_pkg::highest_set(down_mask);
      end else begin
        seek.idx = ets_pkg::lowest_set(up_mask);
      end
    end
  end

endmodule

>>> hw/rtl/ets_core.sv
`include "elevator_target_selector_top_macros.svh"

module ets_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  ets_pkg::item_t   item,
  output ets_pkg::result_t result
);

  logic [ets_pkg::FLOORS-1:0] req_r, req_nxt;
  logic [ets_pkg::PF_W-1:0]   floor_r, floor_nxt;
  logic                       up_r, up_nxt;
  logic                       busy_r, busy_nxt;

  logic                       floor_ok;
  logic [ets_pkg::PF_W-1:0]   fidx;
  logic [ets_pkg::FLOORS-1:0] onehot;
  logic                       searching;
  ets_pkg::seek_t             seek;

  assign floor_ok = ({1'b0, item.floor} < (ets_pkg::FLOOR_W + 1)'(ets_pkg::FLOORS));
  assign fidx     = item.floor[ets_pkg::PF_W-1:0];
  assign onehot   = ets_pkg::FLOORS'(1) << fidx;

  always_comb begin
    req_nxt   = req_r;
    floor_nxt = floor_r;
    up_nxt    = up_r;
    busy_nxt  = busy_r;
    searching = 1'b0;
    if (floor_ok) begin
      unique case (item.operation)
        ets_pkg::OP_REQUEST: begin
          req_nxt   = req_r | onehot;
          busy_nxt  = 1'b1;
          searching = 1'b1;
        end
        ets_pkg::OP_ARRIVE: begin
          req_nxt   = req_r & ~onehot;
          busy_nxt  = |req_nxt;
          searching = 1'b1;
        end
        ets_pkg::OP_PASS: begin
          floor_nxt = fidx;
          up_nxt    = item.moving_up;
        end
        default: begin
        end
      endcase
    end
  end

  ets_seek u_seek (
    .req           (req_nxt),
    .present_floor (floor_r),
    .heading_up    (up_r),
    .seek          (seek)
  );

  always_comb begin
    result.target_valid = searching && seek.found;
    result.target_floor = result.target_valid ? ets_pkg::FLOOR_W'(seek.idx) : '0;
    result.car_busy     = busy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r   <= '0;
      floor_r <= '0;
      up_r    <= 1'b0;
      busy_r  <= 1'b0;
    end else if (advance) begin
      req_r   <= req_nxt;
      floor_r <= floor_nxt;
      up_r    <= up_nxt;
      busy_r  <= busy_nxt;
    end
  end

  `ETS_ASSERT_ALWAYS(a_busy_tracks_requests, busy_r == (|req_r), "busy flag disagrees with requests")

endmodule

>>> hw/rtl/elevator_target_selector_top.sv
// Path: an accepted item is loaded into the input register; its result is computed from there
// and is loaded into the result register once the output has room, then offered on the outputs.
// Throughput: one item per cycle. The input stalls only while both registers hold items
// and out_ready is low.
// The result is formed by the single pass from the input register through the floor search.
// Reset (synchronous, rst_n low) clears all requests, the floor, heading and busy flag.
`include "elevator_target_selector_top_macros.svh"

module elevator_target_selector_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ets_pkg::OP_W-1:0]     in_operation,
  input  logic [ets_pkg::FLOOR_W-1:0]  in_floor,
  input  logic                         in_moving_up,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_target_valid,
  output logic [ets_pkg::FLOOR_W-1:0]  out_target_floor,
  output logic                         out_car_busy
);

  logic             in_v_r;
  ets_pkg::item_t   item_r;
  logic             out_v_r;
  ets_pkg::result_t res_r;
  ets_pkg::result_t res_nxt;
  logic             out_room;
  logic             advance;

  assign out_room = !out_v_r || out_ready;
  assign advance  = in_v_r && out_room;
  assign in_ready = !in_v_r || out_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.operation <= in_operation;
      item_r.floor     <= in_floor;
      item_r.moving_up <= in_moving_up;
    end
  end

  ets_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .result  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_room) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_target_valid = res_r.target_valid;
  assign out_target_floor = res_r.target_floor;
  assign out_car_busy     = res_r.car_busy;

  `ETS_ASSERT_ALWAYS(a_target_means_busy, !out_v_r || !res_r.target_valid || res_r.car_busy, "target sent while car idle")
  `ETS_ASSERT_ALWAYS(a_no_target_zero, !out_v_r || res_r.target_valid || (res_r.target_floor == '0), "target floor nonzero without target")
  `ETS_ASSERT_NEXT(a_stalled_item_kept, in_v_r && !out_room, in_v_r && $stable(item_r), "held item lost while result stalled")

endmodule
